// ----- rtl/blps_pkg.sv -----
// Shared types and constants for the bilinear line-profile sampler.
// Holds the channel payload structs, register codes and fixed field widths.
// No dependencies.
package blps_pkg;

  // Default sizes of the elevation store and the index mask
  localparam int DEF_MAP_X_BITS = 8;
  localparam int DEF_MAP_Y_BITS = 8;
  localparam int DEF_ELEV_BITS  = 16;
  localparam int DEF_COUNT_BITS = 12;

  // Fixed field widths of the channels
  localparam int MAP_COORD_W  = 8;
  localparam int ELEV_IN_W    = 16;
  localparam int SAMPLE_IDX_W = 12;
  localparam int SAMPLE_VAL_W = 16;

  // Configuration register widths
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 17;
  localparam int COUNT_W = 13;

  // Position arithmetic: t = num / (2 * count), quotient fits POS_W bits
  localparam int DIVISOR_W          = COUNT_W + 1;
  localparam int NUM_W              = 31;
  localparam int QUOT_W             = POS_W;
  localparam int REM_W              = DIVISOR_W;
  localparam int DIV_BITS_PER_STAGE = 5;
  localparam int DIV_STAGES         = (QUOT_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

  localparam int FRAC_W   = 8;
  localparam int WEIGHT_W = 2 * FRAC_W + 1;
  localparam int NUM_BEATS = 4;

  localparam int RSP_FIFO_DEPTH = 4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH,
    REG_MAP_HEIGHT,
    REG_START_X,
    REG_START_Y,
    REG_END_X,
    REG_END_Y,
    REG_SAMPLE_COUNT
  } cfg_reg_e;

  localparam logic [SIZE_W-1:0]  RST_MAP_WIDTH    = 9'd256;
  localparam logic [SIZE_W-1:0]  RST_MAP_HEIGHT   = 9'd256;
  localparam logic [POS_W-1:0]   RST_START_X      = 17'd0;
  localparam logic [POS_W-1:0]   RST_START_Y      = 17'd32768;
  localparam logic [POS_W-1:0]   RST_END_X        = 17'd65536;
  localparam logic [POS_W-1:0]   RST_END_Y        = 17'd32768;
  localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 13'd1000;

  typedef struct packed {
    logic                    req_type;
    logic [MAP_COORD_W-1:0]  map_x;
    logic [MAP_COORD_W-1:0]  map_y;
    logic [ELEV_IN_W-1:0]    elevation_in;
    logic [SAMPLE_IDX_W-1:0] sample_index;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_IDX_W-1:0] sample_index_out;
    logic [SAMPLE_VAL_W-1:0] sample_value;
    logic                    index_error;
  } rsp_t;

endpackage

// ----- rtl/blps_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transaction.
// The payload type is set per instance; no other dependencies.
interface blps_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bilinear_line_profile_sampler.sv -----
// Bilinear line-profile sampler: elevation store, position pipeline and read sequencer.
// Depends on blps_pkg and blps_stream_if.
//
// A write transaction stores one elevation. A sample transaction makes four reads,
// one per neighbor, on the single-port elevation store; a sample whose index is not
// below sample_count reads nothing. Items flow in order through a nine-stage position
// pipeline (input, products, sum, four divider stages of up to five quotient bits,
// clamp, weights) and then through three tail stages (read, multiply, accumulate)
// into a four-entry result queue. Input is taken while results wait in the queue,
// as long as fewer than four samples are started and not yet taken. The store has no
// reset and no clearing pass: read only entries that were written. Write configuration
// only while the block is idle.
module bilinear_line_profile_sampler #(
  parameter int MAP_X_BITS = blps_pkg::DEF_MAP_X_BITS,
  parameter int MAP_Y_BITS = blps_pkg::DEF_MAP_Y_BITS,
  parameter int ELEV_BITS  = blps_pkg::DEF_ELEV_BITS,
  parameter int COUNT_BITS = blps_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [blps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [blps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [blps_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  blps_stream_if.sink                     req_i,
  blps_stream_if.source                   rsp_o
);
  import blps_pkg::*;

  localparam int ADDR_W     = MAP_X_BITS + MAP_Y_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int XW         = (MAP_X_BITS + 1 > SIZE_W) ? MAP_X_BITS + 1 : SIZE_W;
  localparam int YW         = (MAP_Y_BITS + 1 > SIZE_W) ? MAP_Y_BITS + 1 : SIZE_W;
  localparam int CW         = (XW > YW) ? XW : YW;
  localparam int IDX_B      = (COUNT_BITS < SAMPLE_IDX_W) ? COUNT_BITS : SAMPLE_IDX_W;
  localparam logic [SAMPLE_IDX_W-1:0] IDX_MASK = SAMPLE_IDX_W'((64'd1 << IDX_B) - 64'd1);
  localparam int ACC_W      = ELEV_BITS + 2 * FRAC_W;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (2 * FRAC_W - 1));
  localparam int ST_PROD    = 1;
  localparam int ST_NUM     = 2;
  localparam int ST_DIV0    = ST_NUM + 1;
  localparam int ST_CLAMP   = ST_DIV0 + DIV_STAGES;
  localparam int ST_HEAD    = ST_CLAMP + 1;
  localparam int NS         = ST_HEAD + 1;
  localparam int PEND_W     = $clog2(RSP_FIFO_DEPTH + 1);
  localparam int FPTR_W     = $clog2(RSP_FIFO_DEPTH);
  localparam logic [1:0] BEAT_LAST = 2'(NUM_BEATS - 1);

  typedef struct packed {
    req_t req;
    logic err;
  } item_t;

  typedef struct packed {
    logic                    first;
    logic                    last;
    logic                    err;
    logic [SAMPLE_IDX_W-1:0] idx;
    logic [WEIGHT_W-1:0]     wt;
  } beat_t;

  // ---------------------------------------------------------------- configuration
  logic [SIZE_W-1:0]  map_width_q, map_height_q;
  logic [POS_W-1:0]   start_x_q, start_y_q, end_x_q, end_y_q;
  logic [COUNT_W-1:0] sample_count_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q    <= RST_MAP_WIDTH;
      map_height_q   <= RST_MAP_HEIGHT;
      start_x_q      <= RST_START_X;
      start_y_q      <= RST_START_Y;
      end_x_q        <= RST_END_X;
      end_y_q        <= RST_END_Y;
      sample_count_q <= RST_SAMPLE_COUNT;
    end else if (cfg_wr) begin
      case (paddr[APB_ADDR_W-1:2])
        REG_MAP_WIDTH:    map_width_q    <= pwdata[SIZE_W-1:0];
        REG_MAP_HEIGHT:   map_height_q   <= pwdata[SIZE_W-1:0];
        REG_START_X:      start_x_q      <= pwdata[POS_W-1:0];
        REG_START_Y:      start_y_q      <= pwdata[POS_W-1:0];
        REG_END_X:        end_x_q        <= pwdata[POS_W-1:0];
        REG_END_Y:        end_y_q        <= pwdata[POS_W-1:0];
        REG_SAMPLE_COUNT: sample_count_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1:2])
      REG_MAP_WIDTH:    prdata = APB_DATA_W'(map_width_q);
      REG_MAP_HEIGHT:   prdata = APB_DATA_W'(map_height_q);
      REG_START_X:      prdata = APB_DATA_W'(start_x_q);
      REG_START_Y:      prdata = APB_DATA_W'(start_y_q);
      REG_END_X:        prdata = APB_DATA_W'(end_x_q);
      REG_END_Y:        prdata = APB_DATA_W'(end_y_q);
      REG_SAMPLE_COUNT: prdata = APB_DATA_W'(sample_count_q);
      default:          prdata = '0;
    endcase
  end

  // Lane 0 is x, lane 1 is y
  logic [POS_W-1:0]     seg_s [2];
  logic [POS_W-1:0]     seg_e [2];
  logic [CW-1:0]        lim   [2];
  logic [DIVISOR_W-1:0] dvs;

  function automatic logic [CW-1:0] size_limit(logic [SIZE_W-1:0] v, int bits);
    logic [CW-1:0] top;
    logic [CW-1:0] ve;
    top = CW'(1) << bits;
    ve  = CW'(v);
    if (v == '0) return '0;
    else if (ve > top) return top - CW'(1);
    else return ve - CW'(1);
  endfunction

  assign seg_s[0] = start_x_q;
  assign seg_s[1] = start_y_q;
  assign seg_e[0] = end_x_q;
  assign seg_e[1] = end_y_q;
  assign lim[0]   = size_limit(map_width_q, MAP_X_BITS);
  assign lim[1]   = size_limit(map_height_q, MAP_Y_BITS);
  assign dvs      = {sample_count_q, 1'b0};

  // ---------------------------------------------------------------- position pipeline
  logic [NS-1:0] vld_q;
  item_t         item_q [NS];
  item_t         in_item;
  logic          advance;
  logic          head_done;

  assign req_i.ready = advance;
  assign advance     = !vld_q[ST_HEAD] || head_done;

  always_comb begin
    in_item                  = '0;
    in_item.req              = req_i.data;
    in_item.req.sample_index = req_i.data.sample_index & IDX_MASK;
    in_item.err = COUNT_W'(in_item.req.sample_index) >= sample_count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NS-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      item_q[0] <= in_item;
      for (int s = 1; s < NS; s++) item_q[s] <= item_q[s-1];
    end
  end

  // Products and sum: num = s*(2N-k) + e*k + N with k = 2i+1
  logic [NUM_W-1:0]     prod_a_q [2];
  logic [NUM_W-1:0]     prod_b_q [2];
  logic [NUM_W-1:0]     num_q    [2];
  logic [DIVISOR_W-1:0] k_odd;
  logic [DIVISOR_W-1:0] dmk;

  assign k_odd = DIVISOR_W'({item_q[ST_PROD-1].req.sample_index, 1'b1});
  assign dmk   = dvs - k_odd;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int l = 0; l < 2; l++) begin
        prod_a_q[l] <= NUM_W'(seg_s[l]) * NUM_W'(dmk);
        prod_b_q[l] <= NUM_W'(seg_e[l]) * NUM_W'(k_odd);
        num_q[l]    <= prod_a_q[l] + prod_b_q[l] + NUM_W'(sample_count_q);
      end
    end
  end

  // Restoring divider by 2N, five quotient bits per stage, fewer in the last
  logic [REM_W-1:0]  rem_q [DIV_STAGES][2];
  logic [QUOT_W-1:0] nlo_q [DIV_STAGES][2];
  logic [QUOT_W-1:0] quo_q [DIV_STAGES][2];
  logic [REM_W-1:0]  rem_d [DIV_STAGES][2];
  logic [QUOT_W-1:0] nlo_d [DIV_STAGES][2];
  logic [QUOT_W-1:0] quo_d [DIV_STAGES][2];

  always_comb begin
    logic [REM_W-1:0]  r;
    logic [QUOT_W-1:0] n;
    logic [QUOT_W-1:0] q;
    logic [REM_W:0]    t;
    for (int g = 0; g < DIV_STAGES; g++) begin
      for (int l = 0; l < 2; l++) begin
        if (g == 0) begin
          r = num_q[l][NUM_W-1:QUOT_W];
          n = num_q[l][QUOT_W-1:0];
          q = '0;
        end else begin
          r = rem_q[g-1][l];
          n = nlo_q[g-1][l];
          q = quo_q[g-1][l];
        end
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
          if (g * DIV_BITS_PER_STAGE + j < QUOT_W) begin
            t = {r, n[QUOT_W-1]};
            n = {n[QUOT_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
              r = REM_W'(t - {1'b0, dvs});
              q = {q[QUOT_W-2:0], 1'b1};
            end else begin
              r = t[REM_W-1:0];
              q = {q[QUOT_W-2:0], 1'b0};
            end
          end
        end
        rem_d[g][l] = r;
        nlo_d[g][l] = n;
        quo_d[g][l] = q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rem_q <= rem_d;
      nlo_q <= nlo_d;
      quo_q <= quo_d;
    end
  end

  // Clamp cells to the map size in use; a clamped axis takes no fraction
  logic [CW-1:0]     c1_q [2];
  logic [CW-1:0]     c2_q [2];
  logic [FRAC_W-1:0] f_q  [2];

  always_ff @(posedge clk_i) begin
    logic [CW-1:0] cell_idx;
    if (advance) begin
      for (int l = 0; l < 2; l++) begin
        cell_idx = CW'(quo_q[DIV_STAGES-1][l][QUOT_W-1:FRAC_W]);
        if (cell_idx >= lim[l]) begin
          c1_q[l] <= lim[l];
          c2_q[l] <= lim[l];
          f_q[l]  <= '0;
        end else begin
          c1_q[l] <= cell_idx;
          c2_q[l] <= cell_idx + CW'(1);
          f_q[l]  <= quo_q[DIV_STAGES-1][l][FRAC_W-1:0];
        end
      end
    end
  end

  // Weights and addresses of the four neighbors, in read order
  logic [WEIGHT_W-1:0] wt_q   [NUM_BEATS];
  logic [ADDR_W-1:0]   addr_q [NUM_BEATS];
  logic [FRAC_W:0]     w_lo   [2];
  logic [FRAC_W:0]     w_hi   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      w_hi[l] = {1'b0, f_q[l]};
      w_lo[l] = (FRAC_W + 1)'(1 << FRAC_W) - w_hi[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      wt_q[0]   <= WEIGHT_W'(w_lo[0]) * WEIGHT_W'(w_lo[1]);
      wt_q[1]   <= WEIGHT_W'(w_hi[0]) * WEIGHT_W'(w_lo[1]);
      wt_q[2]   <= WEIGHT_W'(w_lo[0]) * WEIGHT_W'(w_hi[1]);
      wt_q[3]   <= WEIGHT_W'(w_hi[0]) * WEIGHT_W'(w_hi[1]);
      addr_q[0] <= {c1_q[1][MAP_Y_BITS-1:0], c1_q[0][MAP_X_BITS-1:0]};
      addr_q[1] <= {c1_q[1][MAP_Y_BITS-1:0], c2_q[0][MAP_X_BITS-1:0]};
      addr_q[2] <= {c2_q[1][MAP_Y_BITS-1:0], c1_q[0][MAP_X_BITS-1:0]};
      addr_q[3] <= {c2_q[1][MAP_Y_BITS-1:0], c2_q[0][MAP_X_BITS-1:0]};
    end
  end

  // ---------------------------------------------------------------- store sequencer
  // All store accesses issue here in item order, one per cycle, so a read never
  // overlaps a write to the same entry.
  item_t             head;
  logic [1:0]        beat_q, beat_d;
  logic [PEND_W-1:0] pend_q, fill_q;
  logic              can_start;
  logic              start;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic              tb_fire;
  beat_t             tb_d;

  assign head      = item_q[ST_HEAD];
  assign can_start = pend_q < PEND_W'(RSP_FIFO_DEPTH);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_q[beat_q];
    head_done = 1'b0;
    start     = 1'b0;
    tb_fire   = 1'b0;
    beat_d    = beat_q;
    tb_d.first = (beat_q == '0) || head.err;
    tb_d.last  = (beat_q == BEAT_LAST) || head.err;
    tb_d.err   = head.err;
    tb_d.idx   = head.req.sample_index;
    tb_d.wt    = head.err ? '0 : wt_q[beat_q];
    if (vld_q[ST_HEAD]) begin
      if (head.req.req_type == REQ_WRITE) begin
        mem_we    = 1'b1;
        mem_addr  = {MAP_Y_BITS'(head.req.map_y), MAP_X_BITS'(head.req.map_x)};
        head_done = 1'b1;
      end else if (head.err) begin
        if (can_start) begin
          tb_fire   = 1'b1;
          start     = 1'b1;
          head_done = 1'b1;
        end
      end else if (beat_q != '0 || can_start) begin
        mem_re    = 1'b1;
        tb_fire   = 1'b1;
        start     = (beat_q == '0);
        head_done = (beat_q == BEAT_LAST);
        beat_d    = beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  logic [ELEV_BITS-1:0] store_mem [STORE_DEPTH];
  logic [ELEV_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= ELEV_BITS'(head.req.elevation_in);
    end else if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- multiply-accumulate
  logic             t1_vld_q, t2_vld_q;
  beat_t            t1_q, t2_q;
  logic [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q, acc_sum;
  logic             push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
    end else begin
      t1_vld_q <= tb_fire;
      t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_fire) t1_q <= tb_d;
    if (t1_vld_q) begin
      t2_q <= t1_q;
      // Skip the data of a zero-weight neighbor; it may never have been written
      prod_q <= (t1_q.wt == '0) ? '0 : ACC_W'(rdata_q) * ACC_W'(t1_q.wt);
    end
    if (t2_vld_q) acc_q <= acc_sum;
  end

  assign acc_sum = (t2_q.first ? ROUND_HALF : acc_q) + prod_q;
  assign push    = t2_vld_q && t2_q.last;

  // ---------------------------------------------------------------- result queue
  rsp_t              fifo_q [RSP_FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  rsp_t              push_data;

  assign push_data.sample_index_out = t2_q.idx;
  assign push_data.sample_value     =
      t2_q.err ? '0 : SAMPLE_VAL_W'(acc_sum[ACC_W-1:2*FRAC_W]);
  assign push_data.index_error      = t2_q.err;

  assign rsp_o.valid = (fill_q != '0);
  assign rsp_o.data  = fifo_q[rd_ptr_q];
  assign pop         = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_data;
  end

  // pend_q counts samples started and not yet taken; it bounds the queue fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      pend_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
      fill_q <= fill_q + PEND_W'(push) - PEND_W'(pop);
      pend_q <= pend_q + PEND_W'(start) - PEND_W'(pop);
    end
  end

  // ---------------------------------------------------------------- assertions
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push |-> (fill_q < PEND_W'(RSP_FIFO_DEPTH)) || pop)
    else $error("result queue written while full");

  a_credit_covers_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pend_q >= fill_q)
    else $error("queued results exceed started samples");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(mem_we && mem_re))
    else $error("store read and written in one cycle");

  a_beat_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
      beat_q != '0 |-> vld_q[ST_HEAD] && head.req.req_type == REQ_SAMPLE && !head.err)
    else $error("read sequence in progress without a valid sample at the head");

  a_last_beat_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mem_re && beat_q == BEAT_LAST |=> t1_vld_q && t1_q.last && beat_q == '0)
    else $error("fourth neighbor read did not close the sample");

endmodule
